[design/tldt_pkg.sv]
// ----------------------------------------------------------------------------
// tldt_pkg
// Shared sizes, codes, types and the name normalizer for the two-level
// directory table.
// ----------------------------------------------------------------------------
package tldt_pkg;

  // Table sizes
  localparam int MAX_DIRS   = 16;
  localparam int MAX_FILES  = 16;
  localparam int NAME_BYTES = 14;

  // Name fields are fixed by the command format: 14 bytes in two 56-bit halves
  localparam int HALF_W   = 56;
  localparam int NAME_W   = 2 * HALF_W;
  localparam int RAW_BYTES = NAME_W / 8;

  // Derived widths
  localparam int DIDX_W  = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int FIDX_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W   = $clog2(MAX_DIRS + 1);
  localparam int FCNT_W  = $clog2(MAX_FILES + 1);
  localparam int SCAN_W  = (CNT_W > FCNT_W) ? CNT_W : FCNT_W;
  localparam int FDEPTH  = MAX_DIRS * MAX_FILES;
  localparam int FADDR_W = $clog2(FDEPTH);

  // Result field widths
  localparam int STATUS_W = 3;
  localparam int FDIR_W   = 4;

  // Command codes
  localparam logic [1:0] CMD_MKDIR  = 2'd0;
  localparam logic [1:0] CMD_MKFILE = 2'd1;
  localparam logic [1:0] CMD_RMFILE = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_CREATED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIR_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIR_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd7;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DSCAN,
    S_SDIR,
    S_FSCAN,
    S_MVRD,
    S_MVWR,
    S_RESP
  } state_t;

  // Directory name memory request
  typedef struct packed {
    logic              we;
    logic [DIDX_W-1:0] waddr;
    logic [NAME_W-1:0] wdata;
    logic [DIDX_W-1:0] raddr;
  } dir_port_t;

  // File name memory request
  typedef struct packed {
    logic               we;
    logic [FADDR_W-1:0] waddr;
    logic [NAME_W-1:0]  wdata;
    logic [FADDR_W-1:0] raddr;
  } file_port_t;

  // Zero every byte after the first zero byte and past NAME_BYTES
  function automatic logic [NAME_W-1:0] norm_name(input logic [HALF_W-1:0] hi,
                                                  input logic [HALF_W-1:0] lo);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] res;
    logic [7:0]        b;
    logic              ended;
    raw   = {hi, lo};
    res   = '0;
    ended = 1'b0;
    for (int j = 0; j < RAW_BYTES; j++) begin
      b = raw[NAME_W-1-8*j -: 8];
      if (j >= NAME_BYTES || ended) begin
        b = 8'd0;
      end else if (b == 8'd0) begin
        ended = 1'b1;
      end
      res[NAME_W-1-8*j -: 8] = b;
    end
    return res;
  endfunction

endpackage

[design/tldt_if.sv]
// ----------------------------------------------------------------------------
// tldt_if
// Command and result channels of the directory table: valid/ready plus word.
// ----------------------------------------------------------------------------
interface tldt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [55:0] dir_name_high;
  logic [55:0] dir_name_low;
  logic [55:0] file_name_high;
  logic [55:0] file_name_low;

  modport source (
    output valid, command, dir_name_high, dir_name_low, file_name_high, file_name_low,
    input  ready
  );
  modport sink (
    input  valid, command, dir_name_high, dir_name_low, file_name_high, file_name_low,
    output ready
  );
endinterface

interface tldt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] found_dir;

  modport source (
    output valid, status, found_dir,
    input  ready
  );
  modport sink (
    input  valid, status, found_dir,
    output ready
  );
endinterface

[design/tldt_ram.sv]
// ----------------------------------------------------------------------------
// tldt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tldt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/tldt_ctrl.sv]
// ----------------------------------------------------------------------------
// tldt_ctrl
// Command sequencer: scans the directory and file name memories, decides the
// status, updates counts and names, and holds the result word.
// ----------------------------------------------------------------------------
module tldt_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  tldt_in_if.sink                             in_chan,
  tldt_out_if.source                          out_chan,
  output tldt_pkg::dir_port_t                 dir_port,
  input  logic [tldt_pkg::NAME_W-1:0]         dir_rdata,
  output tldt_pkg::file_port_t                file_port,
  input  logic [tldt_pkg::NAME_W-1:0]         file_rdata
);
  import tldt_pkg::*;

  state_t                state_r, state_nxt;
  logic [1:0]            cmd_r, cmd_nxt;
  logic [NAME_W-1:0]     dname_r, dname_nxt;
  logic [NAME_W-1:0]     fname_r, fname_nxt;
  logic [CNT_W-1:0]      dir_count_r, dir_count_nxt;
  logic [FCNT_W-1:0]     fcnt_r [MAX_DIRS];
  logic [FCNT_W-1:0]     fcnt_nxt [MAX_DIRS];
  logic [SCAN_W-1:0]     scan_r, scan_nxt;
  logic [SCAN_W-1:0]     pidx_r, pidx_nxt;
  logic                  pend_r, pend_nxt;
  logic [CNT_W-1:0]      di_r, di_nxt;
  logic [FIDX_W-1:0]     fi_r, fi_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [FDIR_W-1:0]     found_dir_r, found_dir_nxt;

  logic                  in_acc;
  logic                  out_load;
  logic [DIDX_W-1:0]     di_idx;
  logic [DIDX_W-1:0]     pdi_idx;
  logic [FCNT_W-1:0]     cnt_cur;
  logic [FCNT_W-1:0]     cnt_pidx;
  logic [FADDR_W-1:0]    fbase;
  logic                  dir_full;
  logic                  file_full;
  logic                  d_more, d_hit, d_miss;
  logic                  f_more, f_hit, f_miss;
  logic                  mkdir_wr;
  logic                  mkfile_wr;

  // Shared decode
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_chan.ready);
  assign di_idx    = di_r[DIDX_W-1:0];
  assign pdi_idx   = pidx_r[DIDX_W-1:0];
  assign cnt_cur   = fcnt_r[di_idx];
  assign cnt_pidx  = fcnt_r[pdi_idx];
  assign fbase     = FADDR_W'(FADDR_W'(di_idx) * FADDR_W'(MAX_FILES));
  assign dir_full  = dir_count_r >= CNT_W'(MAX_DIRS);
  assign file_full = cnt_cur >= FCNT_W'(MAX_FILES);

  // Directory scan: one read issued per cycle, compared in the cycle after it is issued
  assign d_more = scan_r < SCAN_W'(dir_count_r);
  assign d_hit  = pend_r && (dir_rdata == dname_r);
  assign d_miss = !pend_r && !d_more;

  // File scan within directory di_r
  assign f_more = scan_r < SCAN_W'(cnt_cur);
  assign f_hit  = pend_r && (file_rdata == fname_r);
  assign f_miss = !pend_r && !f_more;

  assign mkdir_wr  = (state_r == S_DSCAN) && (cmd_r == CMD_MKDIR) && d_miss && !dir_full;
  assign mkfile_wr = (state_r == S_FSCAN) && (cmd_r == CMD_MKFILE) && f_miss && !file_full;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.command == CMD_SEARCH) ? S_SDIR : S_DSCAN;
        end
      end
      S_DSCAN: begin
        if (d_hit) begin
          if (cmd_r == CMD_MKDIR) begin
            state_nxt = S_RESP;
          end else if (cmd_r == CMD_RMFILE && cnt_pidx == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FSCAN;
          end
        end else if (d_miss) begin
          state_nxt = S_RESP;
        end
      end
      S_SDIR: begin
        state_nxt = (di_r >= dir_count_r) ? S_RESP : S_FSCAN;
      end
      S_FSCAN: begin
        if (f_hit) begin
          state_nxt = (cmd_r == CMD_RMFILE) ? S_MVRD : S_RESP;
        end else if (f_miss) begin
          state_nxt = (cmd_r == CMD_SEARCH) ? S_SDIR : S_RESP;
        end
      end
      S_MVRD: state_nxt = S_MVWR;
      S_MVWR: state_nxt = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and bookkeeping updates
  always_comb begin
    cmd_nxt        = cmd_r;
    dname_nxt      = dname_r;
    fname_nxt      = fname_r;
    dir_count_nxt  = dir_count_r;
    fcnt_nxt       = fcnt_r;
    scan_nxt       = scan_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = 1'b0;
    di_nxt         = di_r;
    fi_nxt         = fi_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    status_nxt     = status_r;
    found_dir_nxt  = found_dir_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_chan.command;
          dname_nxt = norm_name(in_chan.dir_name_high, in_chan.dir_name_low);
          fname_nxt = norm_name(in_chan.file_name_high, in_chan.file_name_low);
          scan_nxt  = '0;
          di_nxt    = '0;
        end
      end
      S_DSCAN: begin
        if (d_hit) begin
          di_nxt   = CNT_W'(pidx_r);
          scan_nxt = '0;
          if (cmd_r == CMD_MKDIR) begin
            res_status_nxt = ST_EXISTS;
          end else if (cmd_r == CMD_RMFILE && cnt_pidx == '0) begin
            res_status_nxt = ST_DIR_EMPTY;
          end
        end else if (d_miss) begin
          if (cmd_r != CMD_MKDIR) begin
            res_status_nxt = ST_DIR_INVALID;
          end else if (dir_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            fcnt_nxt[dir_count_r[DIDX_W-1:0]] = '0;
            dir_count_nxt  = dir_count_r + 1'b1;
            res_status_nxt = ST_CREATED;
          end
        end else begin
          // issue the next directory read
          pend_nxt = d_more;
          pidx_nxt = scan_r;
          scan_nxt = d_more ? scan_r + 1'b1 : scan_r;
        end
      end
      S_SDIR: begin
        scan_nxt = '0;
        if (di_r >= dir_count_r) begin
          res_status_nxt = ST_NOT_FOUND;
        end
      end
      S_FSCAN: begin
        if (f_hit) begin
          fi_nxt = pidx_r[FIDX_W-1:0];
          if (cmd_r == CMD_MKFILE) begin
            res_status_nxt = ST_EXISTS;
          end else if (cmd_r == CMD_SEARCH) begin
            res_status_nxt = ST_FOUND;
          end
        end else if (f_miss) begin
          if (cmd_r == CMD_SEARCH) begin
            di_nxt = di_r + 1'b1;
          end else if (cmd_r == CMD_RMFILE) begin
            res_status_nxt = ST_NOT_FOUND;
          end else if (file_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            fcnt_nxt[di_idx] = cnt_cur + 1'b1;
            res_status_nxt   = ST_CREATED;
          end
        end else begin
          // issue the next file read
          pend_nxt = f_more;
          pidx_nxt = scan_r;
          scan_nxt = f_more ? scan_r + 1'b1 : scan_r;
        end
      end
      S_MVRD: begin
      end
      S_MVWR: begin
        fcnt_nxt[di_idx] = cnt_cur - 1'b1;
        res_status_nxt   = ST_DELETED;
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          status_nxt    = res_status_r;
          found_dir_nxt = (res_status_r == ST_FOUND) ? FDIR_W'(di_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory requests and handshake outputs
  always_comb begin
    in_chan.ready   = (state_r == S_IDLE);
    dir_port.we     = mkdir_wr;
    dir_port.waddr  = dir_count_r[DIDX_W-1:0];
    dir_port.wdata  = dname_r;
    dir_port.raddr  = scan_r[DIDX_W-1:0];
    file_port.we    = mkfile_wr || (state_r == S_MVWR);
    file_port.waddr = (state_r == S_MVWR) ? fbase + FADDR_W'(fi_r)
                                          : fbase + FADDR_W'(cnt_cur);
    file_port.wdata = (state_r == S_MVWR) ? file_rdata : fname_r;
    file_port.raddr = (state_r == S_MVRD) ? fbase + FADDR_W'(cnt_cur - 1'b1)
                                          : fbase + FADDR_W'(scan_r);
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.found_dir = found_dir_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_count_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_DIRS; i++) begin
        fcnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      dir_count_r <= dir_count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      fcnt_r      <= fcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    dname_r      <= dname_nxt;
    fname_r      <= fname_nxt;
    scan_r       <= scan_nxt;
    pidx_r       <= pidx_nxt;
    di_r         <= di_nxt;
    fi_r         <= fi_nxt;
    res_status_r <= res_status_nxt;
    status_r     <= status_nxt;
    found_dir_r  <= found_dir_nxt;
  end

`ifndef SYNTHESIS
  a_dir_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dir_count_r <= CNT_W'(MAX_DIRS))
    else $error("directory count past table size");

  a_dir_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dir_port.we |-> (cmd_r == CMD_MKDIR) && (dir_count_r < CNT_W'(MAX_DIRS)))
    else $error("directory write without room or outside mkdir");

  a_file_append_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (file_port.we && state_r == S_FSCAN) |-> cnt_cur < FCNT_W'(MAX_FILES))
    else $error("file append into a full directory");

  a_found_only_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_status_r == ST_FOUND) |-> cmd_r == CMD_SEARCH)
    else $error("found status outside search");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer idle after accepting a word");
`endif

endmodule

[design/two_level_directory_table_unit.sv]
// ----------------------------------------------------------------------------
// two_level_directory_table_unit
// Two-level name table: directory names and per-directory file names kept in
// two synchronous memories, walked by one command sequencer.
// ----------------------------------------------------------------------------
// Steps: a walk over the stored directories to find a directory, then a walk
//   over the files in it, then a read and a write for a delete move; a search
//   walks the files of each stored directory in turn until it finds the file.
// Throughput: one command at a time, bounded by the single read port of the
//   name memory being walked (one entry per cycle).
// Reset: clears directory and file counts and handshake state, not the name memories.
module two_level_directory_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  tldt_in_if.sink     in_chan,
  tldt_out_if.source  out_chan
);
  import tldt_pkg::*;

  dir_port_t         dir_port;
  file_port_t        file_port;
  logic [NAME_W-1:0] dir_rdata;
  logic [NAME_W-1:0] file_rdata;

  // Command sequencer
  tldt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .dir_port   (dir_port),
    .dir_rdata  (dir_rdata),
    .file_port  (file_port),
    .file_rdata (file_rdata)
  );

  // Directory names
  tldt_ram #(
    .WIDTH (NAME_W),
    .DEPTH (MAX_DIRS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_port.we),
    .waddr (dir_port.waddr),
    .wdata (dir_port.wdata),
    .raddr (dir_port.raddr),
    .rdata (dir_rdata)
  );

  // File names, MAX_FILES slots per directory
  tldt_ram #(
    .WIDTH (NAME_W),
    .DEPTH (FDEPTH)
  ) u_file_ram (
    .clk   (clk),
    .we    (file_port.we),
    .waddr (file_port.waddr),
    .wdata (file_port.wdata),
    .raddr (file_port.raddr),
    .rdata (file_rdata)
  );

endmodule
